@@ hdl/spq_pkg.sv @@
// ============================================================================
// spq_pkg: shared definitions for the stable priority queue
// Operation codes, status codes, field widths and default sizing.
// ============================================================================
package spq_pkg;

    // Width of each field in an input word and a result word.
    localparam int FUNC_W   = 2;
    localparam int PRIO_W   = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Widths of the stream data buses, padded up to whole bytes.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // Default number of entries the queue can hold.
    localparam int DEFAULT_CAPACITY = 16;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_t;

    // Status codes returned with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // First and last id handed out by the id counter.
    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
    localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

endpackage

@@ hdl/spq_ram.sv @@
// ============================================================================
// spq_ram: generic simple dual-port RAM
// One write port and one read port on the same clock; read data is
// registered, so it appears the cycle after the address.
// ============================================================================
module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/stable_priority_queue_with_remove_unit.sv @@
// ============================================================================
// stable_priority_queue_with_remove_unit: sorted priority queue with remove
// Bounded queue kept in priority order, highest first, ties in arrival order.
// ============================================================================
// Each input word is one operation: insert, pop or remove by id. The entries
// live in one RAM with a single read and a single write port, and a small
// sequencer walks it one entry per cycle, reading an entry and writing its
// neighbor in the same cycle. An insert scans from the tail toward the head,
// moving each lower-priority entry up by one. Pop and remove by id scan from
// the head, closing the gap behind the match. An insert into a full queue, a
// pop or remove on an empty queue and an unused code go straight to the
// result. The input side is not ready while an operation runs; a finished
// result waits in the output register and the next word is taken while it
// waits. RAM contents need no clearing after reset, since only slots below
// the entry count are read.
module stable_priority_queue_with_remove_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input words.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] func, [9:2] priority_req, [25:10] target_id, [31:26] zero
    input  logic [spq_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // Result words.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [17:2] out_id, [25:18] out_priority, [30:26] occupancy,
    // [31] zero
    output logic [spq_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    import spq_pkg::*;

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WORD_W = ID_W + PRIO_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_RM_RD,
        S_RM_CHK,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [PRIO_W-1:0] prio_req_reg, prio_req_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              found_reg, found_next;
    status_t           res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // RAM port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [ID_W-1:0]   rd_id;
    logic [PRIO_W-1:0] rd_prio;

    // Input word fields.
    logic [FUNC_W-1:0] in_func;
    logic [PRIO_W-1:0] in_prio;
    logic [ID_W-1:0]   in_target;
    logic              hit;
    logic              at_tail;

    assign in_func   = s_axis_tdata[FUNC_W-1:0];
    assign in_prio   = s_axis_tdata[FUNC_W +: PRIO_W];
    assign in_target = s_axis_tdata[FUNC_W+PRIO_W +: ID_W];

    assign rd_prio = ram_rdata[PRIO_W-1:0];
    assign rd_id   = ram_rdata[PRIO_W +: ID_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Entry storage, one word per slot with slot 0 at the head.
    spq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Match for pop is the head slot; for remove, the first id match.
    assign hit = !found_reg &&
                 ((func_reg == FUNC_POP) ? (idx_reg == '0) : (rd_id == target_reg));
    assign at_tail = (CW'(idx_reg) == (count_reg - CW'(1)));

    // Sequencer next-state and RAM control.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        func_next       = func_reg;
        prio_req_next   = prio_req_reg;
        target_next     = target_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    func_next       = in_func;
                    prio_req_next   = in_prio;
                    target_next     = in_target;
                    found_next      = 1'b0;
                    res_status_next = ST_MISS;
                    res_id_next     = '0;
                    res_prio_next   = '0;
                    state_next      = S_FIN;
                    case (in_func)
                        FUNC_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                res_status_next = ST_OK;
                                res_id_next     = next_id_reg;
                                res_prio_next   = in_prio;
                                next_id_next    = (next_id_reg == ID_LAST) ?
                                                  ID_FIRST : next_id_reg + ID_W'(1);
                                if (count_reg == '0) begin
                                    idx_next   = '0;
                                    state_next = S_INS_PUT;
                                end else begin
                                    idx_next   = AW'(count_reg - CW'(1));
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                        FUNC_POP, FUNC_REMOVE: begin
                            if (count_reg != '0) begin
                                idx_next   = '0;
                                state_next = S_RM_RD;
                            end
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                state_next = S_INS_CHK;
            end

            // Walk toward the head, moving lower-priority entries up a slot.
            S_INS_CHK: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                if (rd_prio < prio_req_reg) begin
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0) begin
                        state_next = S_INS_PUT;
                    end else begin
                        ram_raddr = idx_reg - AW'(1);
                        idx_next  = idx_reg - AW'(1);
                    end
                end else begin
                    ram_wdata  = {res_id_reg, prio_req_reg};
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
            end

            S_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = {res_id_reg, prio_req_reg};
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end

            S_RM_RD: begin
                state_next = S_RM_CHK;
            end

            // Walk toward the tail; after the match, move each entry down a slot.
            S_RM_CHK: begin
                ram_raddr = idx_reg + AW'(1);
                if (found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (hit) begin
                    found_next      = 1'b1;
                    res_status_next = ST_OK;
                    res_id_next     = rd_id;
                    res_prio_next   = rd_prio;
                end
                if (at_tail) begin
                    if (found_reg || hit) begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_FIN;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Hand the result to the output register once it is free.
            S_FIN: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({OCC_W'(count_reg), res_prio_reg,
                                              res_id_reg, res_status_reg});
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            next_id_reg <= ID_FIRST;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
        func_reg       <= func_next;
        prio_req_reg   <= prio_req_next;
        target_reg     <= target_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        m_data_reg     <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // The entry count never exceeds the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Every RAM write lands inside the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (CW'(ram_waddr) < CW'(CAPACITY)))
        else $error("RAM write outside the queue");

    // The id counter never hands out zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg != '0)
        else $error("id counter reached zero");

    // In the cycle after a word is taken, the input side is closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an operation runs");
`endif

endmodule

@@ tb/sv/stable_priority_queue_with_remove_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// stable_priority_queue_with_remove_unit_tb: self-checking bench for the queue
// Sends insert, pop, remove and unused-code words through the input stream
// and tracks the queue contents in a shadow copy. Each result word is checked
// field by field against the outcome the shadow copy gives. The run has a
// directed opening, then random words that drift the queue between empty and
// full, with one pause in the middle until every result is back.
// ============================================================================
module stable_priority_queue_with_remove_unit_tb;
    import spq_pkg::*;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int RANDOM_WORDS = 400;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    // The fourth func code has no operation behind it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Fields are listed from the top bit down, so the packed struct matches tdata.
    typedef struct packed {
        logic [ID_W-1:0]   target;
        logic [PRIO_W-1:0] prio;
        logic [FUNC_W-1:0] func;
    } pq_op_t;

    typedef struct packed {
        logic [OCC_W-1:0]    occ;
        logic [PRIO_W-1:0]   prio;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } pq_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the queue; slot 0 is the head.
    logic [ID_W-1:0]   pq_id   [CAP];
    logic [PRIO_W-1:0] pq_prio [CAP];
    int                held       = 0;
    logic [ID_W-1:0]   pq_next_id = ID_FIRST;

    pq_op_t     op_backlog[$];
    pq_result_t due_results[$];
    pq_result_t want_res;
    pq_result_t got_res;

    int errors    = 0;
    int gap_cnt   = 0;
    int stall_cnt = 0;
    bit no_idle   = 1'b0;
    bit fill_bias = 1'b1;

    stable_priority_queue_with_remove_unit #(
        .CAPACITY(CAP)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Applies one operation to the shadow queue and returns its result word.
    function automatic pq_result_t queue_apply(pq_op_t op);
        pq_result_t r;
        int slot;
        int i;
        r = '{status: ST_MISS, id: '0, prio: '0, occ: '0};
        slot = -1;
        case (op.func)
            FUNC_INSERT: begin
                if (held >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    // Shift lower priorities back; equal ones stay ahead.
                    slot = held;
                    for (i = held - 1; i >= 0 && pq_prio[i] < op.prio; i--) begin
                        pq_id[i + 1]   = pq_id[i];
                        pq_prio[i + 1] = pq_prio[i];
                        slot = i;
                    end
                    pq_id[slot]   = pq_next_id;
                    pq_prio[slot] = op.prio;
                    held++;
                    r.status = ST_OK;
                    r.id     = pq_next_id;
                    r.prio   = op.prio;
                    pq_next_id = (pq_next_id == ID_LAST) ? ID_FIRST : pq_next_id + 16'd1;
                end
            end
            FUNC_POP: begin
                if (held > 0) slot = 0;
            end
            FUNC_REMOVE: begin
                for (i = 0; i < held && slot < 0; i++) begin
                    if (pq_id[i] == op.target) slot = i;
                end
            end
            default: begin
            end
        endcase
        // Pop and remove close the gap behind the entry taken out.
        if (op.func != FUNC_INSERT && slot >= 0) begin
            r.status = ST_OK;
            r.id     = pq_id[slot];
            r.prio   = pq_prio[slot];
            for (i = slot; i < held - 1; i++) begin
                pq_id[i]   = pq_id[i + 1];
                pq_prio[i] = pq_prio[i + 1];
            end
            held--;
        end
        r.occ = OCC_W'(held);
        return r;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    task automatic push_op(logic [FUNC_W-1:0] f, logic [PRIO_W-1:0] p, logic [ID_W-1:0] t);
        op_backlog.push_back('{target: t, prio: p, func: f});
    endtask

    task automatic wait_idle();
        while (op_backlog.size() != 0 || due_results.size() != 0) @(negedge aclk);
    endtask

    // Random words in small batches. Each batch is drawn from the queue state
    // once the previous batch is taken, so removes can aim at held ids.
    task automatic random_words(int total);
        int made;
        int n;
        int pick;
        int i;
        pq_op_t op;
        made = 0;
        while (made < total) begin
            while (op_backlog.size() != 0) @(negedge aclk);
            if ($urandom_range(0, 7) == 0) fill_bias = !fill_bias;
            if ($urandom_range(0, 11) == 0) no_idle = !no_idle;
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                op.prio   = PRIO_W'($urandom_range(0, 255));
                op.target = ID_W'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    op.func = FUNC_UNUSED;
                end else if (pick < (fill_bias ? 70 : 35)) begin
                    op.func = FUNC_INSERT;
                end else if (pick < (fill_bias ? 85 : 65)) begin
                    op.func = FUNC_POP;
                end else begin
                    op.func = FUNC_REMOVE;
                end
                // Force ties: reuse a held priority or one of the extremes.
                if (op.func == FUNC_INSERT && $urandom_range(0, 2) == 0) begin
                    if (held > 0 && $urandom_range(0, 1) == 0) begin
                        op.prio = pq_prio[$urandom_range(0, held - 1)];
                    end else begin
                        op.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    end
                end
                // Mostly aim at a held id; zero and random ids usually miss.
                if (op.func == FUNC_REMOVE) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7 && held > 0) begin
                        op.target = pq_id[$urandom_range(0, held - 1)];
                    end else if (pick == 7) begin
                        op.target = '0;
                    end
                end
                op_backlog.push_back(op);
                if (op.func != FUNC_UNUSED) made++;
            end
        end
    endtask

    // Driver: presents backlog words and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(queue_apply(op_backlog.pop_front()));
                if (!no_idle && $urandom_range(0, 2) == 0) gap_cnt = idle_len();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_DATA_W'(op_backlog[0]);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word and stalls the result side at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $error("result word with no operation pending: %h", m_axis_tdata);
                    errors++;
                end else begin
                    want_res = due_results.pop_front();
                    got_res  = pq_result_t'(m_axis_tdata[$bits(pq_result_t)-1:0]);
                    check_field("status", int'(want_res.status), int'(got_res.status));
                    check_field("out_id", int'(want_res.id), int'(got_res.id));
                    check_field("out_priority", int'(want_res.prio), int'(got_res.prio));
                    check_field("occupancy", int'(want_res.occ), int'(got_res.occ));
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall_cnt = idle_len();
            end
            m_axis_tready <= (stall_cnt == 0);
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("stable_priority_queue_with_remove_unit_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int i;

        // Misses on an empty queue, and the unused code with every field bit set.
        push_op(FUNC_POP, 8'd0, 16'd0);
        push_op(FUNC_REMOVE, 8'd0, 16'd1);
        push_op(FUNC_UNUSED, 8'hFF, 16'hFFFF);
        // Both priority extremes, a tie with the head and a middle priority.
        push_op(FUNC_INSERT, 8'd255, 16'd0);
        push_op(FUNC_INSERT, 8'd0, 16'hFFFF);
        push_op(FUNC_INSERT, 8'd255, 16'd0);
        push_op(FUNC_INSERT, 8'd128, 16'd0);
        // Target id zero never matches.
        push_op(FUNC_REMOVE, 8'd0, 16'd0);
        // Take the tied entry out of the middle, then pop the head.
        push_op(FUNC_REMOVE, 8'd0, 16'd3);
        push_op(FUNC_POP, 8'd0, 16'd0);
        // Fill to capacity, then one insert too many.
        for (i = 0; i < CAP - 2; i++) begin
            push_op(FUNC_INSERT, PRIO_W'($urandom_range(0, 255)),
                    ID_W'($urandom_range(0, 65535)));
        end
        push_op(FUNC_INSERT, 8'd255, 16'd0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        random_words(RANDOM_WORDS / 2);

        // Let every result come back before the sender goes on.
        no_idle = 1'b0;
        wait_idle();
        repeat ($urandom_range(5, 30)) @(negedge aclk);

        random_words(RANDOM_WORDS - RANDOM_WORDS / 2);

        // Wait for the last results, then watch a while for stray words.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("stable_priority_queue_with_remove_unit_tb: done, clean");
        end else begin
            $display("stable_priority_queue_with_remove_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
